### hdl/ddpi_pkg.sv
// Package for the differential-drive PI speed controller.
// Holds format constants, register indexes and the sequencer opcodes.
// No dependencies.
package ddpi_pkg;
	localparam int VALUE_FRAC_BITS_DEF = 16;
	localparam int DRIVE_FRAC_BITS_DEF = 14;
	localparam int CFG_W = 31;
	localparam int VAL_W = 32;
	localparam int DRV_W = 16;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPACING = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAXRATE = 3'd2;
	localparam logic [IDX_W-1:0] REG_KP      = 3'd3;
	localparam logic [IDX_W-1:0] REG_KI      = 3'd4;

	// Input item kinds.
	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [30:0] RST_RADIUS  = 31'd2163;
	localparam logic [30:0] RST_SPACING = 31'd6554;
	localparam logic [30:0] RST_MAXRATE = 31'd1376256;
	localparam logic [30:0] RST_KP      = 31'd6554;
	localparam logic [30:0] RST_KI      = 31'd6554;

	// Largest magnitude held by a Q16.16 state register.
	localparam logic [63:0] LIM32 = 64'd2147483647;

	// Divider request: magnitude numerator, denominator, fraction bits, limit.
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] mag;
		logic [32:0] den;
		logic [4:0]  fb;
		logic [31:0] lim;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
		logic        neg;
	} div_rsp_t;
endpackage

### hdl/differential_drive_pi_speed_control_core.sv
// Differential-drive PI wheel speed controller top level.
// A motion command runs 4 divider passes before its result is valid. A control
// tick runs 4 multiply steps and 2 passes. An output stall holds off the next
// input until the result is taken. Idle ticks give no result and the next input
// can be taken in the next cycle. Reset is asynchronous, active low, restores
// register defaults and clears the control state, but not the operand, product
// and drive registers.
module differential_drive_pi_speed_control_core #(
	parameter int VALUE_FRAC_BITS = ddpi_pkg::VALUE_FRAC_BITS_DEF,
	parameter int DRIVE_FRAC_BITS = ddpi_pkg::DRIVE_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic signed [31:0] linear_velocity,
	input  logic signed [31:0] angular_velocity,
	input  logic signed [31:0] left_measured_rate,
	input  logic signed [31:0] right_measured_rate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] left_drive,
	output logic signed [15:0] right_drive,
	output logic        moving
);
	import ddpi_pkg::*;

	localparam int ONE_D = 1 << DRIVE_FRAC_BITS;
	localparam logic [31:0] DLIM = 32'((ONE_D > 32767) ? 32767 : ONE_D);

	localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_DIV = 4'd2,
		S_WAIT = 4'd3, S_OUT = 4'd4, S_PI = 4'd5;

	logic [30:0] radius_q, spacing_q, maxrate_q, kp_q, ki_q;
	logic [3:0]  st_q;
	logic [2:0]  step_q;
	logic        moving_q;
	logic signed [31:0] v_q, w_q, lm_q, rm_q;
	logic signed [31:0] lt_q, rt_q, li_q, ri_q;
	logic signed [63:0] ws_q, lp_q, rp_q;
	logic signed [15:0] ld_q, rd_q;
	logic [30:0]        mul_b;
	logic signed [64:0] prod_full;
	logic signed [63:0] prod;
	div_req_t dreq;
	div_req_t dargs_q;
	logic     dstart_q;
	logic     issue;
	div_rsp_t drsp;
	logic signed [31:0] dres;

	assign cfg_ready = (st_q == S_IDLE) && !out_valid;
	assign in_stall  = (st_q != S_IDLE) || out_valid;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RST_RADIUS; spacing_q <= RST_SPACING;
			maxrate_q <= RST_MAXRATE; kp_q <= RST_KP; ki_q <= RST_KI;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS:  radius_q  <= cfg_data[30:0];
				REG_SPACING: spacing_q <= cfg_data[30:0];
				REG_MAXRATE: maxrate_q <= cfg_data[30:0];
				REG_KP:      kp_q      <= cfg_data[30:0];
				REG_KI:      ki_q      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// One shared signed multiplier, floor-shifted by the value format.
	always_comb begin
		mul_b = spacing_q;
		case (step_q)
			3'd0: mul_b = spacing_q;
			3'd1: mul_b = kp_q;
			3'd2: mul_b = ki_q;
			3'd3: mul_b = kp_q;
			3'd4: mul_b = ki_q;
			default: ;
		endcase
	end
	logic signed [32:0] mul_a_x;
	assign mul_a_x = (step_q == 3'd0) ? 33'(w_q) :
		(step_q < 3'd3) ? 33'(lt_q) - 33'(lm_q) : 33'(rt_q) - 33'(rm_q);
	assign prod_full = mul_a_x * $signed({1'b0, mul_b});
	assign prod = 64'(prod_full >>> VALUE_FRAC_BITS);

	// The start strobe is raised for one cycle each time the sequencer issues a pass.
	assign issue = (st_q == S_MUL) || ((st_q == S_PI) && (step_q == 3'd4)) ||
		((st_q == S_WAIT) && drsp.done && (step_q inside {3'd0, 3'd1, 3'd2, 3'd4}));
	always_comb begin
		dreq = dargs_q;
		dreq.start = dstart_q;
	end

	ddpi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	assign dres = drsp.neg ? -$signed(drsp.res) : $signed(drsp.res);

	// Start helper: build a divider request from a signed numerator.
	function automatic div_req_t mk(input logic signed [63:0] n, input logic [32:0] d,
		input logic [4:0] fb, input logic [31:0] l);
		div_req_t r;
		r.start = 1'b1; r.neg = n[63]; r.mag = n[63] ? 64'(-n) : 64'(n);
		r.den = d; r.fb = fb; r.lim = l;
		return r;
	endfunction

	logic signed [63:0] isum;
	logic signed [63:0] isat;
	assign isum = (step_q < 3'd3 ? 64'(li_q) : 64'(ri_q)) + prod;
	assign isat = (isum > $signed(LIM32)) ? $signed(LIM32) :
		(isum < -$signed(LIM32)) ? -$signed(LIM32) : isum;

	logic [32:0] den2;
	assign den2 = {1'b0, radius_q, 1'b0};
	localparam logic [4:0] VFB = 5'(VALUE_FRAC_BITS);
	localparam logic [4:0] DFB = 5'(DRIVE_FRAC_BITS);

	// Sequencer: walks the multiply and divide steps of each item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; step_q <= '0; moving_q <= 1'b0; out_valid <= 1'b0;
			lt_q <= '0; rt_q <= '0; li_q <= '0; ri_q <= '0;
			dargs_q <= '0; dstart_q <= 1'b0;
		end else begin
			dstart_q <= issue;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					v_q <= linear_velocity; w_q <= angular_velocity;
					lm_q <= left_measured_rate; rm_q <= right_measured_rate;
					if (opcode == OP_MOVE) begin
						step_q <= 3'd0; st_q <= S_MUL;
					end else if (moving_q) begin
						step_q <= 3'd1; st_q <= S_PI;
					end
				end
				S_MUL: begin
					ws_q <= prod;
					dargs_q <= mk(64'(2 * 64'(v_q)) + prod, den2, VFB, LIM32[31:0]);
					step_q <= 3'd0; st_q <= S_WAIT;
				end
				S_PI: begin
					case (step_q)
						3'd1: lp_q <= prod;
						3'd2: li_q <= 32'(isat);
						3'd3: rp_q <= prod;
						default: ri_q <= 32'(isat);
					endcase
					if (step_q == 3'd4) begin
						dargs_q <= mk(lp_q + 64'(li_q), {2'b0, maxrate_q}, DFB, DLIM);
						step_q <= 3'd4; st_q <= S_WAIT;
					end else step_q <= step_q + 3'd1;
				end
				S_WAIT: if (drsp.done) begin
					// Step codes: motion 0..3 (rt, lt, ld, rd), tick 4..5 (ld, rd).
					case (step_q)
						3'd0: begin rt_q <= dres; step_q <= 3'd1;
							dargs_q <= mk(64'(2 * 64'(v_q)) - ws_q, den2, VFB,
								LIM32[31:0]); end
						3'd1: begin lt_q <= dres; step_q <= 3'd2;
							dargs_q <= mk(64'(dres), {2'b0, maxrate_q}, DFB, DLIM); end
						3'd2: begin ld_q <= 16'(dres); step_q <= 3'd3;
							dargs_q <= mk(64'(rt_q), {2'b0, maxrate_q}, DFB, DLIM); end
						3'd3: begin rd_q <= 16'(dres); st_q <= S_OUT;
							li_q <= '0; ri_q <= '0;
							moving_q <= (ld_q != 0) || (dres != 0); end
						3'd4: begin ld_q <= 16'(dres); step_q <= 3'd5;
							dargs_q <= mk(rp_q + 64'(ri_q), {2'b0, maxrate_q}, DFB,
								DLIM); end
						default: begin rd_q <= 16'(dres); st_q <= S_OUT;
							if (ld_q == 0 && dres == 0) moving_q <= 1'b0; end
					endcase
				end
				S_OUT: begin out_valid <= 1'b1; st_q <= S_IDLE; end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign left_drive  = ld_q;
	assign right_drive = rd_q;
	assign moving      = moving_q;
endmodule

### hdl/ddpi_div.sv
// Shared restoring divider: trunc(mag * 2^fb / den), saturated to lim.
// Depends on ddpi_pkg. One quotient bit per cycle, 88 steps per quotient.
module ddpi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ddpi_pkg::div_req_t req,
	output ddpi_pkg::div_rsp_t rsp
);
	import ddpi_pkg::*;

	// Shifted numerator is at most 62+24 bits; quotient capped at lim.
	localparam int NW = 88;
	logic [NW-1:0] num_q;
	logic [32:0]   den_q;
	logic [33:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [6:0]    cnt_q;
	logic          busy_q, done_q, neg_q, dzero_q, mzero_q;
	logic [31:0]   lim_q;
	logic [33:0]   trial;

	assign trial = {rem_q[32:0], num_q[NW-1]} - {1'b0, den_q};

	// Iterate one bit per cycle; saturate at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				num_q <= NW'(req.mag) << req.fb;
				den_q <= req.den;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 7'(NW);
				neg_q <= req.neg;
				lim_q <= req.lim;
				dzero_q <= (req.den == '0);
				mzero_q <= (req.mag == '0);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (!trial[33]) begin
					rem_q <= trial;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[32:0], num_q[NW-1]};
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Saturated magnitude; a zero numerator gives zero, a zero divisor the limit.
	always_comb begin
		rsp.done = done_q;
		rsp.neg = neg_q;
		if (mzero_q)
			rsp.res = '0;
		else if (dzero_q || (quo_q > NW'(lim_q)))
			rsp.res = lim_q;
		else
			rsp.res = quo_q[31:0];
	end
endmodule
